// ----- rtl/core/ssh_pkg.sv -----
// Shared types and constants for the staggered Schrodinger stencil half-step.
`timescale 1ns / 1ps
`default_nettype none

package ssh_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int POS_BITS    = 32;
    localparam int CFG_BITS    = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_BITS-1:0] COUPLING_RESET  = 32'd134217728;
    localparam logic [CFG_BITS-1:0] TIME_STEP_RESET = 32'd13469017;

    // Fixed-point widths of the back-end arithmetic.
    localparam int SQ_W        = 2 * POS_BITS;
    localparam int PROD_W      = CFG_BITS + POS_BITS;
    localparam int VD_SHIFT    = 27;
    localparam int K_W         = PROD_W - VD_SHIFT + 1;
    localparam int KLO_W       = 32;
    localparam int KHI_W       = K_W - KLO_W;
    localparam int LR_SUM_W    = SAMPLE_BITS + 1;
    localparam int LR_PROD_W   = SAMPLE_BITS + 35;
    localparam int CKL_W       = SAMPLE_BITS + KLO_W + 1;
    localparam int CKH_W       = SAMPLE_BITS + KHI_W + 1;
    localparam int ACC_W       = SAMPLE_BITS + 42;
    localparam int FRAC_SHIFT  = 30;

    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPDATE_REAL = 2'd0,
        CFG_COUPLING    = 2'd1,
        CFG_TIME_STEP   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                update_real;
        logic [CFG_BITS-1:0] coupling_coeff;
        logic [CFG_BITS-1:0] time_step;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_ZERO,
        JOB_INTERIOR,
        JOB_INTERIOR_LAST
    } job_kind_t;

    typedef struct packed {
        job_kind_t                      kind;
        logic                           done;
        logic signed [SAMPLE_BITS-1:0]  left;
        logic signed [SAMPLE_BITS-1:0]  centre;
        logic signed [SAMPLE_BITS-1:0]  right;
        logic signed [SAMPLE_BITS-1:0]  own;
        logic signed [POS_BITS-1:0]     pos;
    } job_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_RUN
    } phase_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQUARE,
        B_SCALE,
        B_COEF,
        B_PROD,
        B_SUM,
        B_ACC,
        B_ZERO
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/schrodinger_stencil_half_step.sv -----
// Top level of the staggered Schrodinger stencil half-step with its configuration registers.
//
// Channel  Dir  Beat contents
// s_*      in   s_own_value, s_other_value, s_position, s_final_point
// m_*      out  m_new_value, m_pass_done, m_saturated
// cfg_*    in   cfg_index, cfg_data
//
// The front end takes a beat in any cycle in which the two-entry job queue has room.
// The back-end sequencer steps an interior point through pop, square of the
// position, two time-step products, coefficient sum, stencil products, sum, accumulate
// and clip, a boundary result through pop and zero, and adds a closing boundary result
// to a pass; it works on one job at a time, and accumulate and zero wait for the output.
// Synchronous active-low aresetn restores the register defaults and starts a new pass.
// A waiting result sits in the output register while the back end works on the next job.
`timescale 1ns / 1ps
`default_nettype none

module schrodinger_stencil_half_step (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [ssh_pkg::SAMPLE_BITS-1:0] s_own_value,
    input  wire logic signed [ssh_pkg::SAMPLE_BITS-1:0] s_other_value,
    input  wire logic signed [ssh_pkg::POS_BITS-1:0]    s_position,
    input  wire logic                                   s_final_point,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [ssh_pkg::SAMPLE_BITS-1:0]      m_new_value,
    output logic                                        m_pass_done,
    output logic                                        m_saturated,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [ssh_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [ssh_pkg::CFG_BITS-1:0]           cfg_data
);
    import ssh_pkg::*;

    cfg_t cfg_reg;
    logic q_push, q_ready, q_valid, q_pop;
    job_t q_push_job, q_pop_job;
    logic cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.update_real    <= 1'b1;
            cfg_reg.coupling_coeff <= COUPLING_RESET;
            cfg_reg.time_step      <= TIME_STEP_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_UPDATE_REAL: cfg_reg.update_real    <= cfg_data[0];
                CFG_COUPLING:    cfg_reg.coupling_coeff <= cfg_data;
                CFG_TIME_STEP:   cfg_reg.time_step      <= cfg_data;
                default:         cfg_reg                <= cfg_reg;
            endcase
        end
    end

    ssh_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_own_value   (s_own_value),
        .s_other_value (s_other_value),
        .s_position    (s_position),
        .s_final_point (s_final_point),
        .q_push        (q_push),
        .q_job         (q_push_job),
        .q_ready       (q_ready)
    );

    ssh_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop_job    (q_pop_job),
        .pop        (q_pop)
    );

    ssh_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_job       (q_pop_job),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_value (m_new_value),
        .m_pass_done (m_pass_done),
        .m_saturated (m_saturated)
    );

endmodule

`default_nettype wire

// ----- rtl/core/ssh_fifo.sv -----
// Two-entry job queue between the classifying front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none

module ssh_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire ssh_pkg::job_t push_job,
    output logic               push_ready,
    output logic               pop_valid,
    output ssh_pkg::job_t      pop_job,
    input  wire logic          pop
);
    import ssh_pkg::*;

    job_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("job queue count beyond depth");

    a_push_only_with_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> push_ready)
        else $error("job pushed into a full queue");

    a_pop_only_when_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> pop_valid)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/ssh_front.sv -----
// Front end: accepts grid points, keeps the three-point window and queues result jobs.
`timescale 1ns / 1ps
`default_nettype none

module ssh_front (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [ssh_pkg::SAMPLE_BITS-1:0] s_own_value,
    input  wire logic signed [ssh_pkg::SAMPLE_BITS-1:0] s_other_value,
    input  wire logic signed [ssh_pkg::POS_BITS-1:0]    s_position,
    input  wire logic                                   s_final_point,
    output logic                                        q_push,
    output ssh_pkg::job_t                               q_job,
    input  wire logic                                   q_ready
);
    import ssh_pkg::*;

    phase_t                        phase_reg, phase_next;
    logic signed [SAMPLE_BITS-1:0] other_prev_two_reg;
    logic signed [SAMPLE_BITS-1:0] other_prev_one_reg;
    logic signed [SAMPLE_BITS-1:0] own_prev_one_reg;
    logic signed [POS_BITS-1:0]    position_prev_one_reg;
    logic                          accept;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_FIRST:  phase_next = s_final_point ? PH_FIRST : PH_SECOND;
                PH_SECOND: phase_next = s_final_point ? PH_FIRST : PH_RUN;
                PH_RUN:    phase_next = s_final_point ? PH_FIRST : PH_RUN;
                default:   phase_next = PH_FIRST;
            endcase
        end
    end

    // The second point of a pass waits for its right neighbor and queues nothing, unless it is final.
    always_comb begin
        q_push       = 1'b0;
        q_job.kind   = JOB_ZERO;
        q_job.done   = s_final_point;
        q_job.left   = other_prev_two_reg;
        q_job.centre = other_prev_one_reg;
        q_job.right  = s_other_value;
        q_job.own    = own_prev_one_reg;
        q_job.pos    = position_prev_one_reg;
        unique case (phase_reg)
            PH_FIRST: begin
                q_push = accept;
            end
            PH_SECOND: begin
                q_push = accept && s_final_point;
            end
            PH_RUN: begin
                q_push     = accept;
                q_job.kind = s_final_point ? JOB_INTERIOR_LAST : JOB_INTERIOR;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg             <= PH_FIRST;
            other_prev_two_reg    <= '0;
            other_prev_one_reg    <= '0;
            own_prev_one_reg      <= '0;
            position_prev_one_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            if (accept) begin
                other_prev_two_reg    <= other_prev_one_reg;
                other_prev_one_reg    <= s_other_value;
                own_prev_one_reg      <= s_own_value;
                position_prev_one_reg <= s_position;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ssh_back.sv -----
// Back end: multiply sequencer for the stencil update, saturation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module ssh_back (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire ssh_pkg::cfg_t                          cfg,
    input  wire logic                                   q_valid,
    input  wire ssh_pkg::job_t                          q_job,
    output logic                                        q_pop,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [ssh_pkg::SAMPLE_BITS-1:0]      m_new_value,
    output logic                                        m_pass_done,
    output logic                                        m_saturated
);
    import ssh_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] VAL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] VAL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    back_state_t state_reg, state_next;
    job_t        job_reg;

    logic                        load_job, load_interior, load_zero, out_free;

    logic [POS_BITS-1:0]         pos_u, pos_mag;
    logic [SQ_W-1:0]             p2_reg;
    logic [PROD_W-1:0]           dh_reg, dl_reg, vsum;
    logic [K_W-1:0]              k_reg;
    logic signed [LR_SUM_W-1:0]  sum_lr_reg;
    logic signed [LR_PROD_W-1:0] lr_prod_reg;
    logic signed [CKL_W-1:0]     ck_lo_reg;
    logic signed [CKH_W-1:0]     ck_hi_reg;
    logic signed [ACC_W-1:0]     inner_reg;
    logic signed [ACC_W-1:0]     own_ext, acc, shifted;
    logic [ACC_W-SAMPLE_BITS:0]  acc_top;
    logic signed [SAMPLE_BITS-1:0] clip_value;
    logic                        clip_flag;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_value_reg;
    logic                          out_done_reg;
    logic                          out_sat_reg;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    state_next = (q_job.kind == JOB_ZERO) ? B_ZERO : B_SQUARE;
                end
            end
            B_SQUARE: state_next = B_SCALE;
            B_SCALE:  state_next = B_COEF;
            B_COEF:   state_next = B_PROD;
            B_PROD:   state_next = B_SUM;
            B_SUM:    state_next = B_ACC;
            B_ACC: begin
                if (out_free) begin
                    state_next = (job_reg.kind == JOB_INTERIOR_LAST) ? B_ZERO : B_IDLE;
                end
            end
            B_ZERO: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb begin
        q_pop         = 1'b0;
        load_job      = 1'b0;
        load_interior = 1'b0;
        load_zero     = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                q_pop    = q_valid;
                load_job = q_valid;
            end
            B_ACC:    load_interior = out_free;
            B_ZERO:   load_zero     = out_free;
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Potential term: k = a + floor((d*p2_hi + floor(d*p2_lo / 2^32)) / 2^27), in Q.28.
    assign pos_u   = job_reg.pos;
    assign pos_mag = pos_u[POS_BITS-1] ? (~pos_u + POS_BITS'(1)) : pos_u;
    assign vsum    = dh_reg + PROD_W'(dl_reg[PROD_W-1:POS_BITS]);

    always_ff @(posedge aclk) begin
        if (load_job) begin
            job_reg <= q_job;
        end
        p2_reg      <= SQ_W'(pos_mag) * SQ_W'(pos_mag);
        dh_reg      <= PROD_W'(cfg.time_step) * PROD_W'(p2_reg[SQ_W-1:POS_BITS]);
        dl_reg      <= PROD_W'(cfg.time_step) * PROD_W'(p2_reg[POS_BITS-1:0]);
        k_reg       <= K_W'(cfg.coupling_coeff) + K_W'(vsum[PROD_W-1:VD_SHIFT]);
        sum_lr_reg  <= LR_SUM_W'(job_reg.left) + LR_SUM_W'(job_reg.right);
        lr_prod_reg <= LR_PROD_W'(sum_lr_reg)
                     * LR_PROD_W'($signed({1'b0, cfg.coupling_coeff, 1'b0}));
        ck_lo_reg   <= CKL_W'(job_reg.centre) * CKL_W'($signed({1'b0, k_reg[KLO_W-1:0]}));
        ck_hi_reg   <= CKH_W'(job_reg.centre) * CKH_W'($signed({1'b0, k_reg[K_W-1:KLO_W]}));
        inner_reg   <= ACC_W'(lr_prod_reg)
                     - ((ACC_W'(ck_lo_reg) + (ACC_W'(ck_hi_reg) <<< KLO_W)) <<< 2);
    end

    // The real half-step subtracts the stencil term, the imaginary one adds it.
    assign own_ext = ACC_W'(job_reg.own) <<< FRAC_SHIFT;
    assign acc     = cfg.update_real ? (own_ext - inner_reg) : (own_ext + inner_reg);
    assign shifted = acc >>> FRAC_SHIFT;
    assign acc_top = shifted[ACC_W-1:SAMPLE_BITS-1];

    always_comb begin
        clip_flag  = !((&acc_top) || !(|acc_top));
        clip_value = shifted[SAMPLE_BITS-1:0];
        if (clip_flag) begin
            clip_value = acc[ACC_W-1] ? VAL_MIN : VAL_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_interior || load_zero) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_interior) begin
            out_value_reg <= clip_value;
            out_done_reg  <= 1'b0;
            out_sat_reg   <= clip_flag;
        end else if (load_zero) begin
            out_value_reg <= '0;
            out_done_reg  <= job_reg.done;
            out_sat_reg   <= 1'b0;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_new_value = out_value_reg;
    assign m_pass_done = out_done_reg;
    assign m_saturated = out_sat_reg;

    a_load_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_interior || load_zero) |-> out_free)
        else $error("result register overwritten before its beat was taken");

    a_done_is_zero_boundary: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_done_reg) |-> (out_value_reg == '0 && !out_sat_reg))
        else $error("end-of-pass result is not a clean zero");

    a_pop_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg != B_IDLE))
        else $error("job popped but sequencer stayed idle");

endmodule

`default_nettype wire
